/* hw/rtl/pps_pkg.sv */
package pps_pkg;

    // fixed widths of the channel fields
    localparam int FIELD_WIDTH = 16;

    // one input word
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] value;
        logic                   end_of_stream;
    } in_item_t;

    // one result word
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] prime;
        logic                   done_res;
        logic                   overflow;
    } out_item_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } state_t;

    // control group from sequencer to prime store
    typedef struct packed {
        logic wr;
        logic clear;
        logic rd;
    } store_ctrl_t;

endpackage

/* hw/rtl/pps_store.sv */
module pps_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pps_pkg::store_ctrl_t ctrl,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [WIDTH-1:0]     rd_data,
    output logic [CW-1:0]        count,
    output logic                 full
);
    import pps_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    // append at the fill point, registered read
    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
        if (ctrl.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // fill count
    always_comb begin
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.wr) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;
    assign full    = (count_reg == CW'(DEPTH));

endmodule

/* hw/rtl/pps_serial_mod.sv */
module pps_serial_mod #(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic         rem_zero
);
    import pps_pkg::*;

    localparam int NW = $clog2(W + 1);

    logic [W-1:0]  shift_reg;
    logic [W-1:0]  shift_next;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  div_reg;
    logic [W-1:0]  div_next;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] cnt_next;
    logic          done_reg;
    logic          done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    // one dividend bit enters the partial remainder per cycle
    assign trial = {rem_reg, shift_reg[W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
            cnt_next   = NW'(W);
        end else if (cnt_reg != '0) begin
            shift_next = {shift_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[W-1:0];
            end else begin
                rem_next = trial[W-1:0];
            end
            cnt_next  = cnt_reg - NW'(1);
            done_next = (cnt_reg == NW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0) && (div_reg != '0);

endmodule

/* hw/rtl/pipelined_prime_sieve_top.sv */
// Prime sieve: candidate words enter on s_valid/s_ready/s_data, results
// leave on m_valid/m_ready/m_data. A candidate is checked against every
// stored prime in storage order; a divisible one is dropped with no result.
// A candidate that survives is appended to the store (or flagged overflow
// when the store is full) and comes out as one result word. An
// end_of_stream word empties the store and returns a done word.
// Values below two are dropped without changing the store.
// Timing: one candidate is in work at a time. Each stored prime takes a
// memory read, a load, VALUE_WIDTH steps of the bit-serial remainder unit
// and a step to act on the remainder. The serial remainder unit produces
// one quotient bit per cycle.
// Results sit in an output register; the next candidate is accepted while
// a result waits. If the receiver stalls and a second result is ready, the
// sequencer holds it until m_ready takes the first word.
// Reset (aresetn low, synchronous) empties the store and the output
// register; stored entries are not cleared, the fill count guards them.
module pipelined_prime_sieve_top #(
    parameter int MAX_PRIMES  = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pps_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pps_pkg::out_item_t m_data
);
    import pps_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int AW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int CW = $clog2(MAX_PRIMES + 1);

    state_t        state_reg;
    state_t        state_next;
    logic [W-1:0]  value_reg;
    logic [W-1:0]  value_next;
    logic          eos_reg;
    logic          eos_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic          m_valid_reg;
    logic          m_valid_next;
    out_item_t     m_data_reg;
    out_item_t     m_data_next;

    store_ctrl_t   st_ctrl;
    logic [W-1:0]  rd_data;
    logic [CW-1:0] count;
    logic          full;
    logic          mod_start;
    logic          mod_done;
    logic          rem_zero;

    logic          accept;
    logic          out_free;
    logic          out_load;
    logic          last_idx;
    logic [31:0]   in_wide;
    logic [31:0]   out_wide;
    logic [W-1:0]  in_value;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_idx = ((CW'(idx_reg) + CW'(1)) == count);
    assign in_wide  = 32'(s_data.value);
    assign in_value = in_wide[W-1:0];
    assign out_wide = 32'(value_reg);

    pps_store #(
        .DEPTH (MAX_PRIMES),
        .WIDTH (W),
        .AW    (AW),
        .CW    (CW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (st_ctrl),
        .wr_data (value_reg),
        .rd_addr (idx_reg),
        .rd_data (rd_data),
        .count   (count),
        .full    (full)
    );

    pps_serial_mod #(
        .W (W)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (value_reg),
        .divisor  (rd_data),
        .done     (mod_done),
        .rem_zero (rem_zero)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.end_of_stream) begin
                        state_next = ST_EMIT;
                    end else if (in_value < W'(2)) begin
                        state_next = ST_IDLE;
                    end else if (count == '0) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:  state_next = ST_START;
            ST_START: state_next = ST_WAIT;
            ST_WAIT: begin
                if (mod_done) begin
                    if (rem_zero) begin
                        state_next = ST_IDLE;
                    end else if (last_idx) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready    = 1'b0;
        value_next = value_reg;
        eos_next   = eos_reg;
        idx_next   = idx_reg;
        st_ctrl    = '0;
        mod_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    value_next = in_value;
                    eos_next   = s_data.end_of_stream;
                    idx_next   = '0;
                end
            end
            ST_READ: begin
                st_ctrl.rd = 1'b1;
            end
            ST_START: begin
                mod_start = 1'b1;
            end
            ST_WAIT: begin
                if (mod_done && !rem_zero && !last_idx) begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    st_ctrl.clear = eos_reg;
                    st_ctrl.wr    = !eos_reg && !full;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next         = 1'b1;
            m_data_next.done_res = eos_reg;
            m_data_next.overflow = !eos_reg && full;
            m_data_next.prime    = eos_reg ? '0 : out_wide[FIELD_WIDTH-1:0];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        eos_reg    <= eos_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(MAX_PRIMES))
        else $error("prime store count above depth");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == ST_WAIT))
        else $error("remainder result outside wait state");

    a_eos_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.end_of_stream) |=> (state_reg == ST_EMIT))
        else $error("end of stream word not sent to emit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("pending result word overwritten");

endmodule
